FILE: rtl/afrq_pkg.sv
// Shared types and constants for the acked frame retransmit queue.
// Used by afrq_ram, afrq_ctrl and acked_frame_retransmit_queue; no dependencies.
package afrq_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int SEQ_W   = 32;
  localparam int LEN_W   = 24;
  localparam int CNT_O_W = 7;
  localparam int TOT_W   = 32;
  localparam int IN_DW   = 88;
  localparam int OUT_DW  = 128;

  localparam logic [LEN_W-1:0] BUDGET_RESET = 24'd262144;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BUDGET = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage

FILE: rtl/afrq_ram.sv
// Descriptor memory: one write port, one read port with registered read data.
// Depends on afrq_pkg for the entry type.
module afrq_ram
  import afrq_pkg::*;
#(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(MAX_ENTRIES_DEF)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/afrq_ctrl.sv
// Queue sequencer: head/count/byte bookkeeping, eviction and ack walks,
// result register. Depends on afrq_pkg; drives the afrq_ram ports.
module afrq_ctrl
  import afrq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int AW          = $clog2(MAX_ENTRIES_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  input  logic [LEN_W-1:0]  budget,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output entry_t            wr_data,
  output logic [AW-1:0]     rd_addr,
  input  entry_t            rd_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int SW = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [LEN_W-1:0]  bytes_r, bytes_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [CW-1:0]     drops_r, drops_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              fwd_r, fwd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  entry_t            wdata_r;

  logic [1:0]        cmd_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [LEN_W-1:0]  len_r;
  logic [SEQ_W-1:0]  ack_r;

  logic [AW-1:0]     head_inc;
  logic [SW-1:0]     tail_sum;
  logic [AW-1:0]     tail_slot;
  logic              need_evict;
  logic              ack_hit;
  logic              out_free;
  logic              finish;
  logic              load_out;
  entry_t            hd_raw;
  entry_t            hd;

  assign head_inc  = (head_r == AW'(MAX_ENTRIES - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail_slot = (tail_sum >= SW'(MAX_ENTRIES)) ? AW'(tail_sum - SW'(MAX_ENTRIES))
                                                    : AW'(tail_sum);
  assign need_evict = (count_r >= CW'(MAX_ENTRIES)) ||
                      ((25'(bytes_r) + 25'(len_r)) > 25'(budget));
  assign ack_hit  = (count_r != '0) && (rd_data.seq <= ack_r);
  assign out_free = !out_valid_r || out_tready;

  // The registered read of the freshly written head slot is not yet valid: forward it.
  assign hd_raw = (state_r == S_DONE && fwd_r) ? wdata_r : rd_data;
  assign hd     = (count_r == '0) ? '0 : hd_raw;

  assign in_tready = (state_r == S_IDLE);
  assign rd_addr   = head_nxt;
  assign wr_addr   = tail_slot;
  assign wr_data   = '{seq: seq_r, len: len_r};

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    bytes_nxt  = bytes_r;
    total_nxt  = total_r;
    drops_nxt  = drops_r;
    status_nxt = status_r;
    fwd_nxt    = fwd_r;
    wr_en      = 1'b0;
    finish     = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          drops_nxt  = '0;
          fwd_nxt    = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH: begin
            if (len_r == '0) begin
              status_nxt = ST_ZERO;
              finish     = 1'b1;
            end else if (len_r > budget) begin
              status_nxt = ST_BUDGET;
              finish     = 1'b1;
            end else if (need_evict) begin
              // drop the oldest entry and try again next cycle
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              bytes_nxt = bytes_r - rd_data.len;
              drops_nxt = drops_r + 1'b1;
              total_nxt = total_r + 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_nxt  = count_r + 1'b1;
              bytes_nxt  = bytes_r + len_r;
              fwd_nxt    = (count_r == '0);
              status_nxt = ST_OK;
              state_nxt  = S_DONE;
            end
          end
          CMD_ACK: begin
            if (ack_hit) begin
              head_nxt  = head_inc;
              count_nxt = count_r - 1'b1;
              bytes_nxt = bytes_r - rd_data.len;
            end else begin
              status_nxt = ST_OK;
              finish     = 1'b1;
            end
          end
          CMD_PEEK: begin
            status_nxt = (count_r == '0) ? ST_EMPTY : ST_OK;
            finish     = 1'b1;
          end
          default: begin
            status_nxt = ST_OK;
            finish     = 1'b1;
          end
        endcase
        if (finish) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          fwd_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = {total_r, CNT_O_W'(drops_r), bytes_r, CNT_O_W'(count_r),
                     hd.len, hd.seq, status_nxt};
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      total_r     <= '0;
      drops_r     <= '0;
      status_r    <= ST_OK;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      total_r     <= total_nxt;
      drops_r     <= drops_nxt;
      status_r    <= status_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      seq_r <= in_tdata[31:0];
      len_r <= in_tdata[55:32];
      ack_r <= in_tdata[87:56];
    end
    if (wr_en) begin
      wdata_r <= wr_data;
    end
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> bytes_r == '0)
    else $error("bytes held with no entries");

  a_fwd_single: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> count_r == CW'(1))
    else $error("head forward set with other than one entry");

  a_evict_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r == CMD_PUSH && len_r != '0 && len_r <= budget &&
     need_evict) |=> total_r == $past(total_r) + 1'b1)
    else $error("eviction not counted");

endmodule

FILE: rtl/acked_frame_retransmit_queue.sv
// Top level of the acked frame retransmit queue: budget register, sequencer
// and descriptor memory. Depends on afrq_pkg, afrq_ram and afrq_ctrl.
//
//   channel | dir | handshake           | payload
//   in_     | in  | in_tvalid/in_tready | tuser command, tdata seq/len/ack
//   out_    | out | out_tvalid/tready   | tdata status and queue snapshot
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_data byte budget
//
// Peek, reject and unused commands finish in the execute state; ack removes acked
// head entries; an appending push evicts, writes and passes the done state. The
// walks are set by the single memory read port, one head entry per cycle.
// Reset is synchronous; the memory needs no clearing, only held entries are read.
// A stalled result holds in the output register while the next request is taken.
module acked_frame_retransmit_queue
  import afrq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [31:0] frame_seq, [55:32] frame_len, [87:56] ack_seq
  input  logic [IN_DW-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [1:0] status, [33:2] head_seq, [57:34] head_len, [64:58] entry_count,
  // [88:65] bytes_held, [95:89] drops_now, [127:96] evict_total
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [LEN_W-1:0] budget_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      budget_r <= cfg_data;
    end
  end

  afrq_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .budget     (budget_r),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  afrq_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
